/* rtl/dro_pkg.sv */
`timescale 1ns / 1ps

package dro_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 32;
	localparam int ATAN_DEPTH   = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
	localparam int STEP_W       = $clog2(CORDIC_ITERS);
	localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

	localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] INV_PI_Q20  = 32'sd333772;

	localparam int SPEED_W   = 24;
	localparam int TIME_W    = 20;
	localparam int ACC_W     = 48;
	localparam int PHASE_W   = 32;
	localparam int POS_W     = 32;
	localparam int QUAT_W    = 16;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 2 * POS_W + PHASE_W + 2 * QUAT_W;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_SPEED  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGULAR_SPEED = 1'd1;

	localparam logic [SPEED_W-1:0] LINEAR_SPEED_RST  = 24'd6554;
	localparam logic [SPEED_W-1:0] ANGULAR_SPEED_RST = 24'd6554;

	// atan(2^-i), 2^32 = 2*pi
	function automatic logic [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: begin r = 32'h20000000; end
			5'd1: begin r = 32'h12E4051D; end
			5'd2: begin r = 32'h09FB385B; end
			5'd3: begin r = 32'h051111D4; end
			5'd4: begin r = 32'h028B0D43; end
			5'd5: begin r = 32'h0145D7E1; end
			5'd6: begin r = 32'h00A2F61E; end
			5'd7: begin r = 32'h00517C55; end
			5'd8: begin r = 32'h0028BE53; end
			5'd9: begin r = 32'h00145F2E; end
			5'd10: begin r = 32'h000A2F98; end
			5'd11: begin r = 32'h000517CC; end
			5'd12: begin r = 32'h00028BE6; end
			5'd13: begin r = 32'h000145F3; end
			5'd14: begin r = 32'h0000A2F9; end
			5'd15: begin r = 32'h0000517C; end
			5'd16: begin r = 32'h000028BE; end
			5'd17: begin r = 32'h0000145F; end
			5'd18: begin r = 32'h00000A2F; end
			5'd19: begin r = 32'h00000517; end
			5'd20: begin r = 32'h0000028B; end
			5'd21: begin r = 32'h00000145; end
			5'd22: begin r = 32'h000000A2; end
			5'd23: begin r = 32'h00000051; end
			default: begin r = 32'h0; end
		endcase
		return r;
	endfunction

	// Q2.30 -> Q1.15, round half up, saturate
	function automatic logic [QUAT_W-1:0] to_q15(input logic signed [33:0] v);
		logic signed [34:0] sum;
		logic signed [19:0] r;
		logic [QUAT_W-1:0] q;
		sum = 35'(v) + 35'sd16384;
		r = 20'(sum >>> 15);
		if (r > 20'sd32767) begin
			q = 16'h7FFF;
		end else if (r < -20'sd32768) begin
			q = 16'h8000;
		end else begin
			q = r[QUAT_W-1:0];
		end
		return q;
	endfunction

endpackage

/* rtl/dead_reckoning_odometry_core.sv */
`timescale 1ns / 1ps

// Unicycle dead-reckoning odometry. Each input word carries the elapsed time since the
// previous tick (2^-20 s units). The core advances x/y by linear_speed * dt along the
// heading held before the tick, advances the heading by angular_speed * dt, and returns
// pos_x, pos_y (Q16.16 m, wrapping), the heading phase (2^32 = 4*pi) and the yaw
// quaternion z/w (Q1.15). An accepted word goes through two 16-step rotation CORDIC
// passes on one shift-add unit, six products on a single shared 32x32 multiplier plus
// the heading add, a reload state and an output state. A new word is accepted only
// while the sequencer is idle, so the next word is not taken until the last has left
// it. A finished result sits in the output register and does not block the next
// accept; the word after it waits in the sequencer until that register is taken.
// Speed registers are written through the cfg port; the user keeps this to while the core is idle (not enforced).
module dead_reckoning_odometry_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dro_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dro_pkg::SPEED_W-1:0]          cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [dro_pkg::IN_TDATA_W-1:0]       s_tdata,   // [19:0] elapsed_time
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dro_pkg::OUT_TDATA_W-1:0]      m_tdata    // pos_x, pos_y, heading, quat_z, quat_w
);
	import dro_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_C1   = 4'd1;
	localparam logic [3:0] ST_MVT  = 4'd2;
	localparam logic [3:0] ST_MD   = 4'd3;
	localparam logic [3:0] ST_MX   = 4'd4;
	localparam logic [3:0] ST_MY   = 4'd5;
	localparam logic [3:0] ST_MHI  = 4'd6;
	localparam logic [3:0] ST_MLO  = 4'd7;
	localparam logic [3:0] ST_HEAD = 4'd8;
	localparam logic [3:0] ST_C2I  = 4'd9;
	localparam logic [3:0] ST_C2   = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	localparam logic signed [32:0] Z_QUARTER = 33'sh0_4000_0000;
	localparam logic signed [32:0] Z_HALF    = 33'sh0_8000_0000;
	localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CORDIC_ITERS - 1);

	logic [3:0]                state_q;
	logic [SPEED_W-1:0]        lin_q;
	logic [SPEED_W-1:0]        ang_q;
	logic [TIME_W-1:0]         t_q;
	logic [ACC_W-1:0]          x_acc_q;
	logic [ACC_W-1:0]          y_acc_q;
	logic [PHASE_W-1:0]        heading_q;

	logic signed [33:0]        cx_q;
	logic signed [33:0]        cy_q;
	logic signed [32:0]        cz_q;
	logic                      cneg_q;
	logic [STEP_W-1:0]         step_q;

	logic signed [63:0]        prod_q;
	logic signed [27:0]        d_q;
	logic [43:0]               p_q;
	logic [35:0]               hi_q;

	logic                      out_valid_q;
	logic [POS_W-1:0]          out_x_q;
	logic [POS_W-1:0]          out_y_q;
	logic [PHASE_W-1:0]        out_h_q;
	logic [QUAT_W-1:0]         out_qz_q;
	logic [QUAT_W-1:0]         out_qw_q;

	logic                      in_fire;
	logic                      out_free;
	logic                      cordic_init;
	logic                      cordic_run;
	logic [31:0]               angle;
	logic signed [32:0]        z_in;
	logic signed [32:0]        z_fold;
	logic                      neg_fold;
	logic signed [33:0]        xs;
	logic signed [33:0]        ys;
	logic signed [32:0]        atan_v;
	logic signed [33:0]        c_val;
	logic signed [33:0]        s_val;
	logic signed [31:0]        mul_a;
	logic signed [31:0]        mul_b;
	logic [57:0]               dh_full;

	assign in_fire     = s_tvalid && s_tready;
	assign s_tready    = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || m_tready;
	assign cordic_init = in_fire || (state_q == ST_C2I);
	assign cordic_run  = (state_q == ST_C1) || (state_q == ST_C2);

	// fold angle into [-pi/2, pi/2]
	always_comb begin
		angle = (state_q == ST_IDLE) ? {heading_q[30:0], 1'b0} : heading_q;
		angle = angle & ANGLE_MASK;
		z_in = {angle[31], angle};
		z_fold = z_in;
		neg_fold = 1'b0;
		if (z_in > Z_QUARTER) begin
			z_fold = z_in - Z_HALF;
			neg_fold = 1'b1;
		end else if (z_in < -Z_QUARTER) begin
			z_fold = z_in + Z_HALF;
			neg_fold = 1'b1;
		end
	end

	assign xs     = cx_q >>> step_q;
	assign ys     = cy_q >>> step_q;
	assign atan_v = {1'b0, atan_lut(ATAN_IDX_W'(step_q))};
	assign c_val  = cneg_q ? -cx_q : cx_q;
	assign s_val  = cneg_q ? -cy_q : cy_q;

	always_comb begin
		case (state_q)
			ST_MVT: begin
				mul_a = 32'(signed'(lin_q));
				mul_b = signed'({12'd0, t_q});
			end
			ST_MD: begin
				mul_a = 32'(signed'(ang_q));
				mul_b = INV_PI_Q20;
			end
			ST_MX: begin
				mul_a = c_val[31:0];
				mul_b = 32'(d_q);
			end
			ST_MY: begin
				mul_a = s_val[31:0];
				mul_b = 32'(d_q);
			end
			ST_MHI: begin
				mul_a = 32'(signed'(p_q[43:22]));
				mul_b = signed'({12'd0, t_q});
			end
			ST_MLO: begin
				mul_a = signed'({10'd0, p_q[21:0]});
				mul_b = signed'({12'd0, t_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign dh_full = {hi_q, 22'd0} + prod_q[57:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lin_q       <= LINEAR_SPEED_RST;
			ang_q       <= ANGULAR_SPEED_RST;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			heading_q   <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LINEAR_SPEED: begin lin_q <= cfg_data; end
					REG_ANGULAR_SPEED: begin ang_q <= cfg_data; end
					default: begin end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cordic_run) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_C1;
					end
				end
				ST_C1: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_MVT;
					end
				end
				ST_MVT: begin state_q <= ST_MD; end
				ST_MD: begin state_q <= ST_MX; end
				ST_MX: begin state_q <= ST_MY; end
				ST_MY: begin
					x_acc_q <= x_acc_q + {{2{prod_q[63]}}, prod_q[63:18]};
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					y_acc_q <= y_acc_q + {{2{prod_q[63]}}, prod_q[63:18]};
					state_q <= ST_MLO;
				end
				ST_MLO: begin state_q <= ST_HEAD; end
				ST_HEAD: begin
					heading_q <= heading_q + dh_full[57:26];
					state_q <= ST_C2I;
				end
				ST_C2I: begin state_q <= ST_C2; end
				ST_C2: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin state_q <= ST_IDLE; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_fire) begin
			t_q <= s_tdata[TIME_W-1:0];
		end
		if (cordic_init) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= z_fold;
			cneg_q <= neg_fold;
		end else if (cordic_run) begin
			if (!cz_q[32]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
		end
		if (state_q == ST_MD) begin
			d_q <= prod_q[43:16];
		end
		if (state_q == ST_MX) begin
			p_q <= prod_q[43:0];
		end
		if (state_q == ST_MLO) begin
			hi_q <= prod_q[35:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_x_q  <= x_acc_q[47:16];
			out_y_q  <= y_acc_q[47:16];
			out_h_q  <= heading_q;
			out_qz_q <= to_q15(s_val);
			out_qw_q <= to_q15(c_val);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_qw_q, out_qz_q, out_h_q, out_y_q, out_x_q};

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_C1))
		else $error("accept did not start first rotation pass");

	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_HEAD) |=> (heading_q == $past(heading_q)))
		else $error("heading changed outside update step");

	a_xacc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MY) |=> $stable(x_acc_q))
		else $error("x accumulator changed outside its step");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished word not presented");

	a_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_C2I) |-> (step_q == '0))
		else $error("rotation step counter not cleared between passes");
`endif

endmodule

/* test/tb_dead_reckoning_odometry_core.sv */
`timescale 1ns / 1ps

module tb_dead_reckoning_odometry_core;
	import dro_pkg::*;

	typedef struct {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic [PHASE_W-1:0]       heading;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [QUAT_W-1:0] quat_w;
	} pose_t;

	// atan(2^-i), 2^32 = 2*pi
	localparam longint ATAN_TAB [0:23] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
		64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint HALF_TURN    = 64'sd2147483648;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [SPEED_W-1:0]         cfg_data = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [IN_TDATA_W-1:0]      s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]     m_tdata;

	// predictor state
	logic signed [SPEED_W-1:0]  lin_speed = LINEAR_SPEED_RST;
	logic signed [SPEED_W-1:0]  ang_speed = ANGULAR_SPEED_RST;
	logic [ACC_W-1:0]           x_acc = '0;
	logic [ACC_W-1:0]           y_acc = '0;
	logic [PHASE_W-1:0]         phase_acc = '0;

	logic [TIME_W-1:0]          tick_q[$];
	pose_t                      pose_q[$];
	pose_t                      exp_pose;

	int gap_max = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	int results_seen = 0;
	int fail_cnt = 0;

	dead_reckoning_odometry_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// angle: 2^32 = 2*pi, returns cos and sin in Q2.30
	function automatic void rotate_vec(input logic [31:0] angle, output longint cos_q30,
			output longint sin_q30);
		logic signed [31:0] folded;
		longint x, y, z, xs, ys;
		bit flip;
		folded = angle & ANGLE_MASK;
		z = folded;
		x = CORDIC_GAIN;
		y = 0;
		flip = 1'b0;
		if (z > QUARTER_TURN) begin
			z = z - HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z = z + HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TAB[i];
			end
		end
		cos_q30 = flip ? -x : x;
		sin_q30 = flip ? -y : y;
	endfunction

	function automatic logic [QUAT_W-1:0] half_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32768) begin
			r = -32768;
		end
		return r[QUAT_W-1:0];
	endfunction

	function automatic pose_t advance_pose(input logic [TIME_W-1:0] dt);
		pose_t p;
		longint t, v, w, dist_q20, c, s;
		t = dt;
		v = lin_speed;
		w = ang_speed;
		dist_q20 = (v * t) >>> 16;
		rotate_vec({phase_acc[PHASE_W-2:0], 1'b0}, c, s);
		x_acc = x_acc + ACC_W'((dist_q20 * c) >>> 18);
		y_acc = y_acc + ACC_W'((dist_q20 * s) >>> 18);
		phase_acc = phase_acc + PHASE_W'((w * t * longint'(INV_PI_Q20)) >>> 26);
		rotate_vec(phase_acc, c, s);
		p.pos_x = x_acc[ACC_W-1:16];
		p.pos_y = y_acc[ACC_W-1:16];
		p.heading = phase_acc;
		p.quat_z = half_q15(s);
		p.quat_w = half_q15(c);
		return p;
	endfunction

	function automatic logic [TIME_W-1:0] random_dt();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return TIME_W'($urandom);
		end else if (r < 8) begin
			return TIME_W'($urandom_range(0, 255));
		end else if (r == 8) begin
			return TIME_W'($urandom_range(20'hFFF00, 20'hFFFFF));
		end
		return TIME_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		int r;
		r = $urandom_range(0, 3);
		if (r == 1) begin
			return SPEED_W'($urandom_range(0, 131072) - 65536);
		end else if (r == 2) begin
			r = $urandom_range(0, 2);
			return (r == 0) ? 24'h7FFFFF : (r == 1) ? 24'h800000 : 24'h000000;
		end
		return SPEED_W'($urandom);
	endfunction

	task automatic drain();
		while (tick_q.size() != 0 || pose_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic set_speeds(input logic [SPEED_W-1:0] lin, input logic [SPEED_W-1:0] ang);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_LINEAR_SPEED;
		cfg_data <= lin;
		@(posedge clk);
		cfg_index <= REG_ANGULAR_SPEED;
		cfg_data <= ang;
		@(posedge clk);
		cfg_we <= 1'b0;
		lin_speed = lin;
		ang_speed = ang;
	endtask

	// sender: bursts of words with random gaps, holds a word until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pose_q.push_back(advance_pose(s_tdata[TIME_W-1:0]));
				void'(tick_q.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'(tick_q[0]);
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pose_q.size() == 0) begin
					$error("result word with no expectation pending");
					fail_cnt++;
				end else begin
					exp_pose = pose_q.pop_front();
					if (m_tdata[31:0] !== exp_pose.pos_x) begin
						$error("pos_x: expected %0d, got %0d", exp_pose.pos_x,
							$signed(m_tdata[31:0]));
						fail_cnt++;
					end
					if (m_tdata[63:32] !== exp_pose.pos_y) begin
						$error("pos_y: expected %0d, got %0d", exp_pose.pos_y,
							$signed(m_tdata[63:32]));
						fail_cnt++;
					end
					if (m_tdata[95:64] !== exp_pose.heading) begin
						$error("heading: expected %0d, got %0d", exp_pose.heading,
							m_tdata[95:64]);
						fail_cnt++;
					end
					if (m_tdata[111:96] !== exp_pose.quat_z) begin
						$error("quat_z: expected %0d, got %0d", exp_pose.quat_z,
							$signed(m_tdata[111:96]));
						fail_cnt++;
					end
					if (m_tdata[127:112] !== exp_pose.quat_w) begin
						$error("quat_w: expected %0d, got %0d", exp_pose.quat_w,
							$signed(m_tdata[127:112]));
						fail_cnt++;
					end
				end
				results_seen++;
				if (results_seen % 500 == 250) begin
					hold_left = 600;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset speeds, zero tick first: unit quaternion at the origin
		tick_q.push_back(20'h00000);
		tick_q.push_back(20'h00001);
		tick_q.push_back(20'hFFFFF);
		tick_q.push_back(20'hAAAAA);
		tick_q.push_back(20'h55555);
		tick_q.push_back(20'h80000);
		tick_q.push_back(20'h00000);
		tick_q.push_back(20'h7FFFF);

		// top speeds: heading wraps within one word
		set_speeds(24'h7FFFFF, 24'h7FFFFF);
		gap_max = 5;
		stall_pct = 30;
		repeat (4) tick_q.push_back(20'hFFFFF);
		tick_q.push_back(20'h00000);
		tick_q.push_back(20'h00001);

		set_speeds(24'h800000, 24'h800000);
		repeat (4) tick_q.push_back(20'hFFFFF);
		tick_q.push_back(20'h00000);
		tick_q.push_back(20'h12345);

		set_speeds(24'h000000, 24'h000000);
		gap_max = 0;
		stall_pct = 0;
		tick_q.push_back(20'h00001);
		tick_q.push_back(20'hFFFFF);
		tick_q.push_back(20'h00000);

		// straight line at full speed until the position wraps
		set_speeds(24'h7FFFFF, 24'h000000);
		gap_max = 3;
		stall_pct = 20;
		repeat (400) tick_q.push_back(TIME_W'($urandom_range(20'hF0000, 20'hFFFFF)));

		for (int ph = 0; ph < 6; ph++) begin
			set_speeds(pick_speed(), pick_speed());
			case ($urandom_range(0, 2))
				0: begin gap_max = 0; end
				1: begin gap_max = 4; end
				default: begin gap_max = 40; end
			endcase
			case ($urandom_range(0, 2))
				0: begin stall_pct = 0; end
				1: begin stall_pct = 25; end
				default: begin stall_pct = 60; end
			endcase
			repeat (170) tick_q.push_back(random_dt());
		end

		drain();
		if (fail_cnt == 0 && pose_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
